// ----- hdl/pfre_pkg.sv -----
package pfre_pkg;

  localparam int VPAGES     = 64;
  localparam int FRAMES     = 16;
  localparam int MAX_SHIFT  = 12;

  localparam int PG_W   = $clog2(VPAGES);
  localparam int FR_W   = $clog2(FRAMES);
  localparam int LEN_W  = PG_W + 1;
  localparam int FIU_W  = FR_W + 1;
  localparam int OFF_W  = 18;
  localparam int SH_W   = 4;
  localparam int PA_W   = 16;
  localparam int CFG_W  = 7;

  // Configuration register indexes.
  localparam logic [1:0] CFG_POLICY     = 2'd0;
  localparam logic [1:0] CFG_NUM_FRAMES = 2'd1;
  localparam logic [1:0] CFG_PAGE_SHIFT = 2'd2;
  localparam logic [1:0] CFG_NUM_PAGES  = 2'd3;

  localparam logic POLICY_FIFO = 1'b0;

  // Fault causes.
  localparam logic [2:0] CAUSE_READ_NEW      = 3'd0;
  localparam logic [2:0] CAUSE_WRITE_NEW     = 3'd1;
  localparam logic [2:0] CAUSE_WRITE_RO      = 3'd2;
  localparam logic [2:0] CAUSE_WRITE_WRITABLE = 3'd3;
  localparam logic [2:0] CAUSE_READ_RESIDENT = 3'd4;

  localparam logic [1:0] DIRTY_ALL = 2'b11;
  localparam logic [1:0] DIRTY_OLD = 2'b01;

  typedef struct packed {
    logic            listed;
    logic            resident;
    logic [FR_W-1:0] frame;
    logic            read_only;
    logic            referenced;
    logic [1:0]      dirty;
  } attr_t;

  typedef struct packed {
    logic            we;
    logic [PG_W-1:0] waddr;
    attr_t           wdata;
    logic [PG_W-1:0] raddr;
  } attr_req_t;

  typedef struct packed {
    logic            we;
    logic [PG_W-1:0] waddr;
    logic [PG_W-1:0] wdata;
    logic [PG_W-1:0] raddr;
  } ord_req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOOK,
    ST_F_RDORD,
    ST_F_RDATTR,
    ST_F_CHK,
    ST_F_SHRD,
    ST_F_SHWR,
    ST_F_PG,
    ST_F_SRD,
    ST_F_SCMP,
    ST_C_RDORD,
    ST_C_RDATTR,
    ST_C_CHK,
    ST_C_APP,
    ST_FIN
  } state_t;

endpackage

// ----- hdl/pfre_attr_ram.sv -----
// Per-page mark store. Entries never written read as all zero through the
// touched bits, which reset clears at once.
module pfre_attr_ram (
  input  logic               clk,
  input  logic               rst,
  input  pfre_pkg::attr_req_t req,
  output pfre_pkg::attr_t     rdata
);

  pfre_pkg::attr_t mem [pfre_pkg::VPAGES];
  pfre_pkg::attr_t rd_q;
  logic [pfre_pkg::VPAGES-1:0] touched;
  logic hit_q;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd_q <= mem[req.raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      touched <= '0;
      hit_q   <= 1'b0;
    end else begin
      if (req.we) begin
        touched[req.waddr] <= 1'b1;
      end
      hit_q <= touched[req.raddr];
    end
  end

  assign rdata = hit_q ? rd_q : '0;

endmodule

// ----- hdl/pfre_order_ram.sv -----
// Page list store, one write and one registered read per cycle.
module pfre_order_ram (
  input  logic                          clk,
  input  pfre_pkg::ord_req_t             req,
  output logic [pfre_pkg::PG_W-1:0]      rdata
);

  logic [pfre_pkg::PG_W-1:0] mem [pfre_pkg::VPAGES];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

// ----- hdl/page_fault_replacement_engine_unit.sv -----
// Channel   Direction  Handshake             Payload
// input     in         in_valid / in_stall   fault_offset, is_write
// output    out        out_valid / out_stall bad_address, virtual_page, cause,
//                                            evicted_page, write_back,
//                                            physical_address
// config    in         cfg_we                cfg_index, cfg_data
//
// A word is finished without a walk when the page is resident, a free frame
// is left or the offset is bad. A replacement walks the page list one entry
// at a time through the list and mark memories, one read and one write port
// each: FIFO scans for the first resident page, moves the list entries behind
// it and, for a page that is already listed, searches for that page too; the
// clock walk visits pages from the hand until it evicts one or a full pass finds none resident.
// Reset is synchronous and clears the control state and the touched bits of
// the mark memory; the list memory needs no clearing. The next word is taken
// while a result waits under out_stall; only its finish waits for the slot.
module page_fault_replacement_engine_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [pfre_pkg::OFF_W-1:0]         fault_offset,
  input  logic                               is_write,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               bad_address,
  output logic [pfre_pkg::PG_W-1:0]          virtual_page,
  output logic [2:0]                         cause,
  output logic signed [pfre_pkg::PG_W:0]     evicted_page,
  output logic                               write_back,
  output logic [pfre_pkg::PA_W-1:0]          physical_address,
  input  logic                               cfg_we,
  input  logic [1:0]                         cfg_index,
  input  logic [pfre_pkg::CFG_W-1:0]         cfg_data
);

  // Configuration registers.
  logic                          policy;
  logic [pfre_pkg::FIU_W-1:0]    frame_limit;
  logic [pfre_pkg::SH_W-1:0]     page_shift;
  logic [pfre_pkg::LEN_W-1:0]    num_pages;

  // Effective limits after clamping.
  logic [pfre_pkg::SH_W-1:0]     shift;
  logic [pfre_pkg::LEN_W-1:0]    np;
  logic [pfre_pkg::FIU_W-1:0]    nf;
  logic [pfre_pkg::OFF_W-1:0]    pg_wide;
  logic                          bad_in;
  logic [pfre_pkg::OFF_W-1:0]    off_mask;

  // Sequencer state.
  pfre_pkg::state_t state, state_next;
  logic [pfre_pkg::PG_W-1:0]     pg, pg_next;
  logic [pfre_pkg::MAX_SHIFT-1:0] poff, poff_next;
  logic                          wr, wr_next;
  logic                          bad, bad_next;
  logic                          is_new, is_new_next;
  pfre_pkg::attr_t               pattr, pattr_next;
  logic [pfre_pkg::FR_W-1:0]     frame, frame_next;
  logic signed [pfre_pkg::PG_W:0] evicted, evicted_next;
  logic                          wb, wb_next;
  logic [2:0]                    cause_q, cause_next;
  logic [pfre_pkg::LEN_W-1:0]    k, k_next;
  logic [pfre_pkg::LEN_W-1:0]    j, j_next;
  logic                          phase, phase_next;
  logic [pfre_pkg::PG_W-1:0]     v, v_next;
  logic                          start0, start0_next;
  logic                          any, any_next;
  logic [pfre_pkg::LEN_W-1:0]    len, len_next;
  logic [pfre_pkg::LEN_W-1:0]    cp, cp_next;
  logic [pfre_pkg::FIU_W-1:0]    fiu, fiu_next;
  logic                          out_load;

  pfre_pkg::attr_req_t           attr_req;
  pfre_pkg::attr_t               attr_rdata;
  pfre_pkg::ord_req_t            ord_req;
  logic [pfre_pkg::PG_W-1:0]     ord_rdata;

  logic accept;
  logic room;

  pfre_attr_ram u_attr (
    .clk   (clk),
    .rst   (rst),
    .req   (attr_req),
    .rdata (attr_rdata)
  );

  pfre_order_ram u_order (
    .clk   (clk),
    .req   (ord_req),
    .rdata (ord_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      policy      <= pfre_pkg::POLICY_FIFO;
      frame_limit <= pfre_pkg::FIU_W'(pfre_pkg::FRAMES);
      page_shift  <= pfre_pkg::SH_W'(pfre_pkg::MAX_SHIFT);
      num_pages   <= pfre_pkg::LEN_W'(pfre_pkg::VPAGES);
    end else if (cfg_we) begin
      case (cfg_index)
        pfre_pkg::CFG_POLICY:     policy      <= cfg_data[0];
        pfre_pkg::CFG_NUM_FRAMES: frame_limit <= cfg_data[pfre_pkg::FIU_W-1:0];
        pfre_pkg::CFG_PAGE_SHIFT: page_shift  <= cfg_data[pfre_pkg::SH_W-1:0];
        pfre_pkg::CFG_NUM_PAGES:  num_pages   <= cfg_data[pfre_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Out-of-range register values fold onto the nearest legal value.
  always_comb begin
    shift = (page_shift > pfre_pkg::SH_W'(pfre_pkg::MAX_SHIFT)) ?
            pfre_pkg::SH_W'(pfre_pkg::MAX_SHIFT) : page_shift;
    np = (num_pages > pfre_pkg::LEN_W'(pfre_pkg::VPAGES)) ?
         pfre_pkg::LEN_W'(pfre_pkg::VPAGES) : num_pages;
    if (frame_limit == '0) begin
      nf = pfre_pkg::FIU_W'(1);
    end else if (frame_limit > pfre_pkg::FIU_W'(pfre_pkg::FRAMES)) begin
      nf = pfre_pkg::FIU_W'(pfre_pkg::FRAMES);
    end else begin
      nf = frame_limit;
    end
    pg_wide  = fault_offset >> shift;
    bad_in   = pg_wide >= pfre_pkg::OFF_W'(np);
    off_mask = (pfre_pkg::OFF_W'(1) << shift) - pfre_pkg::OFF_W'(1);
  end

  assign in_stall = (state != pfre_pkg::ST_IDLE);
  assign accept   = in_valid && !in_stall;
  // The list can take one more entry.
  assign room     = (len < pfre_pkg::LEN_W'(pfre_pkg::VPAGES));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pfre_pkg::ST_IDLE;
      len   <= '0;
      cp    <= '0;
      fiu   <= '0;
    end else begin
      state <= state_next;
      len   <= len_next;
      cp    <= cp_next;
      fiu   <= fiu_next;
    end
  end

  always_ff @(posedge clk) begin
    pg      <= pg_next;
    poff    <= poff_next;
    wr      <= wr_next;
    bad     <= bad_next;
    is_new  <= is_new_next;
    pattr   <= pattr_next;
    frame   <= frame_next;
    evicted <= evicted_next;
    wb      <= wb_next;
    cause_q <= cause_next;
    k       <= k_next;
    j       <= j_next;
    phase   <= phase_next;
    v       <= v_next;
    start0  <= start0_next;
    any     <= any_next;
  end

  always_comb begin
    state_next   = state;
    pg_next      = pg;
    poff_next    = poff;
    wr_next      = wr;
    bad_next     = bad;
    is_new_next  = is_new;
    pattr_next   = pattr;
    frame_next   = frame;
    evicted_next = evicted;
    wb_next      = wb;
    cause_next   = cause_q;
    k_next       = k;
    j_next       = j;
    phase_next   = phase;
    v_next       = v;
    start0_next  = start0;
    any_next     = any;
    len_next     = len;
    cp_next      = cp;
    fiu_next     = fiu;
    out_load     = 1'b0;

    attr_req.we    = 1'b0;
    attr_req.waddr = pg;
    attr_req.wdata = attr_rdata;
    attr_req.raddr = pg;
    ord_req.we     = 1'b0;
    ord_req.waddr  = len[pfre_pkg::PG_W-1:0];
    ord_req.wdata  = pg;
    ord_req.raddr  = k[pfre_pkg::PG_W-1:0];

    case (state)
      pfre_pkg::ST_IDLE: begin
        attr_req.raddr = pg_wide[pfre_pkg::PG_W-1:0];
        if (accept) begin
          pg_next      = pg_wide[pfre_pkg::PG_W-1:0];
          poff_next    = pfre_pkg::MAX_SHIFT'(fault_offset & off_mask);
          wr_next      = is_write;
          bad_next     = bad_in;
          evicted_next = '1;
          wb_next      = 1'b0;
          frame_next   = '0;
          state_next   = bad_in ? pfre_pkg::ST_FIN : pfre_pkg::ST_LOOK;
        end
      end

      pfre_pkg::ST_LOOK: begin
        pattr_next            = attr_rdata;
        pattr_next.referenced = 1'b1;
        if (attr_rdata.listed && attr_rdata.resident) begin
          frame_next = attr_rdata.frame;
          if (wr) begin
            cause_next           = attr_rdata.read_only ? pfre_pkg::CAUSE_WRITE_RO :
                                   pfre_pkg::CAUSE_WRITE_WRITABLE;
            pattr_next.read_only = 1'b0;
            pattr_next.dirty     = pfre_pkg::DIRTY_ALL;
          end else begin
            cause_next = pfre_pkg::CAUSE_READ_RESIDENT;
          end
          state_next = pfre_pkg::ST_FIN;
        end else begin
          is_new_next = !attr_rdata.listed;
          if (wr) begin
            cause_next       = pfre_pkg::CAUSE_WRITE_NEW;
            pattr_next.dirty = pfre_pkg::DIRTY_ALL;
          end else begin
            cause_next           = pfre_pkg::CAUSE_READ_NEW;
            pattr_next.read_only = 1'b1;
          end
          if (fiu < nf) begin
            frame_next = fiu[pfre_pkg::FR_W-1:0];
            fiu_next   = fiu + pfre_pkg::FIU_W'(1);
            if (!attr_rdata.listed && room) begin
              ord_req.we = 1'b1;
              len_next   = len + pfre_pkg::LEN_W'(1);
            end
            state_next = pfre_pkg::ST_FIN;
          end else if (policy == pfre_pkg::POLICY_FIFO) begin
            k_next     = '0;
            state_next = pfre_pkg::ST_F_RDORD;
          end else begin
            start0_next = (cp == '0);
            any_next    = 1'b0;
            state_next  = pfre_pkg::ST_C_RDORD;
          end
        end
      end

      // FIFO: find the first resident page in list order.
      pfre_pkg::ST_F_RDORD: begin
        state_next = (k < len) ? pfre_pkg::ST_F_RDATTR : pfre_pkg::ST_F_PG;
      end

      pfre_pkg::ST_F_RDATTR: begin
        attr_req.raddr = ord_rdata;
        v_next         = ord_rdata;
        state_next     = pfre_pkg::ST_F_CHK;
      end

      pfre_pkg::ST_F_CHK: begin
        attr_req.raddr = v;
        if (attr_rdata.resident) begin
          frame_next     = attr_rdata.frame;
          evicted_next   = {1'b0, v};
          wb_next        = |attr_rdata.dirty;
          attr_req.we    = 1'b1;
          attr_req.waddr = v;
          attr_req.wdata = '0;
          attr_req.wdata.listed = attr_rdata.listed;
          j_next         = k;
          phase_next     = 1'b0;
          state_next     = pfre_pkg::ST_F_SHRD;
        end else begin
          k_next     = k + pfre_pkg::LEN_W'(1);
          state_next = pfre_pkg::ST_F_RDORD;
        end
      end

      // Close the gap at j, then put the moved page at the tail.
      pfre_pkg::ST_F_SHRD: begin
        if (j + pfre_pkg::LEN_W'(1) < len) begin
          ord_req.raddr = pfre_pkg::PG_W'(j + pfre_pkg::LEN_W'(1));
          state_next    = pfre_pkg::ST_F_SHWR;
        end else begin
          ord_req.we    = 1'b1;
          ord_req.waddr = j[pfre_pkg::PG_W-1:0];
          ord_req.wdata = phase ? pg : v;
          state_next    = phase ? pfre_pkg::ST_FIN : pfre_pkg::ST_F_PG;
        end
      end

      pfre_pkg::ST_F_SHWR: begin
        ord_req.we    = 1'b1;
        ord_req.waddr = j[pfre_pkg::PG_W-1:0];
        ord_req.wdata = ord_rdata;
        j_next        = j + pfre_pkg::LEN_W'(1);
        state_next    = pfre_pkg::ST_F_SHRD;
      end

      pfre_pkg::ST_F_PG: begin
        if (is_new) begin
          if (room) begin
            ord_req.we = 1'b1;
            len_next   = len + pfre_pkg::LEN_W'(1);
          end
          state_next = pfre_pkg::ST_FIN;
        end else begin
          k_next     = '0;
          state_next = pfre_pkg::ST_F_SRD;
        end
      end

      pfre_pkg::ST_F_SRD: begin
        if (k < len) begin
          state_next = pfre_pkg::ST_F_SCMP;
        end else begin
          if (room) begin
            ord_req.we = 1'b1;
            len_next   = len + pfre_pkg::LEN_W'(1);
          end
          state_next = pfre_pkg::ST_FIN;
        end
      end

      pfre_pkg::ST_F_SCMP: begin
        if (ord_rdata == pg) begin
          j_next     = k;
          phase_next = 1'b1;
          state_next = pfre_pkg::ST_F_SHRD;
        end else begin
          k_next     = k + pfre_pkg::LEN_W'(1);
          state_next = pfre_pkg::ST_F_SRD;
        end
      end

      // Clock walk, one list entry at a time: read the list, read the marks, check.
      pfre_pkg::ST_C_RDORD: begin
        ord_req.raddr = cp[pfre_pkg::PG_W-1:0];
        if (cp < len) begin
          state_next = pfre_pkg::ST_C_RDATTR;
        end else begin
          cp_next = '0;
          if (!any && start0) begin
            state_next = pfre_pkg::ST_C_APP;
          end else begin
            start0_next = 1'b1;
            any_next    = 1'b0;
          end
        end
      end

      pfre_pkg::ST_C_RDATTR: begin
        attr_req.raddr = ord_rdata;
        v_next         = ord_rdata;
        state_next     = pfre_pkg::ST_C_CHK;
      end

      pfre_pkg::ST_C_CHK: begin
        attr_req.raddr = v;
        attr_req.waddr = v;
        cp_next        = cp + pfre_pkg::LEN_W'(1);
        state_next     = pfre_pkg::ST_C_RDORD;
        if (attr_rdata.resident) begin
          any_next    = 1'b1;
          attr_req.we = 1'b1;
          if (attr_rdata.referenced) begin
            attr_req.wdata.referenced = 1'b0;
          end else if (attr_rdata.dirty[1]) begin
            attr_req.wdata.dirty = pfre_pkg::DIRTY_OLD;
          end else begin
            attr_req.wdata.resident = 1'b0;
            attr_req.wdata.frame    = '0;
            attr_req.wdata.dirty    = '0;
            wb_next      = attr_rdata.dirty[0];
            evicted_next = {1'b0, v};
            frame_next   = attr_rdata.frame;
            if (cp + pfre_pkg::LEN_W'(1) >= len) begin
              cp_next = '0;
            end
            state_next = pfre_pkg::ST_C_APP;
          end
        end
      end

      pfre_pkg::ST_C_APP: begin
        if (is_new && room) begin
          ord_req.we = 1'b1;
          len_next   = len + pfre_pkg::LEN_W'(1);
        end
        state_next = pfre_pkg::ST_FIN;
      end

      pfre_pkg::ST_FIN: begin
        if (!out_valid || !out_stall) begin
          out_load = 1'b1;
          if (!bad) begin
            attr_req.we             = 1'b1;
            attr_req.wdata          = pattr;
            attr_req.wdata.listed   = 1'b1;
            attr_req.wdata.resident = 1'b1;
            attr_req.wdata.frame    = frame;
          end
          state_next = pfre_pkg::ST_IDLE;
        end
      end

      default: state_next = pfre_pkg::ST_IDLE;
    endcase
  end

  // Output register: holds a finished word until the consumer takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      bad_address  <= bad;
      virtual_page <= bad ? '0 : pg;
      cause        <= bad ? '0 : cause_q;
      evicted_page <= bad ? '0 : evicted;
      write_back   <= bad ? 1'b0 : wb;
      physical_address <= bad ? '0 :
        (pfre_pkg::PA_W'(frame) << shift) + pfre_pkg::PA_W'(poff);
    end
  end

endmodule

// ----- hdl/pfre_checker.sv -----
module pfre_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic                           bad_address,
  input logic [pfre_pkg::PG_W-1:0]      virtual_page,
  input logic [2:0]                     cause,
  input logic signed [pfre_pkg::PG_W:0] evicted_page,
  input logic                           write_back,
  input logic [pfre_pkg::PA_W-1:0]      physical_address
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(virtual_page) &&
      $stable(evicted_page) && $stable(physical_address) && $stable(cause))
    else $error("result word changed while stalled");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_address |-> virtual_page == '0 && cause == '0 &&
      evicted_page == '0 && !write_back && physical_address == '0)
    else $error("bad address word carries nonzero fields");

  a_cause_code: assert property (@(posedge clk) disable iff (rst)
    out_valid && !bad_address |-> cause <= pfre_pkg::CAUSE_READ_RESIDENT)
    else $error("undefined cause code");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    out_valid && !bad_address &&
      (cause == pfre_pkg::CAUSE_WRITE_RO || cause == pfre_pkg::CAUSE_WRITE_WRITABLE ||
       cause == pfre_pkg::CAUSE_READ_RESIDENT)
      |-> evicted_page == -7'sd1 && !write_back)
    else $error("resident page fault reported an eviction");

  a_wb_victim: assert property (@(posedge clk) disable iff (rst)
    out_valid && write_back |-> !bad_address && !evicted_page[pfre_pkg::PG_W])
    else $error("write-back without an evicted page");

endmodule

bind page_fault_replacement_engine_unit pfre_checker u_pfre_checker (.*);

// ----- sim/page_fault_replacement_engine_unit_tb.sv -----
module page_fault_replacement_engine_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [pfre_pkg::OFF_W-1:0] fault_offset = '0;
  logic is_write = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic bad_address;
  logic [pfre_pkg::PG_W-1:0] virtual_page;
  logic [2:0] cause;
  logic signed [pfre_pkg::PG_W:0] evicted_page;
  logic write_back;
  logic [pfre_pkg::PA_W-1:0] physical_address;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [pfre_pkg::CFG_W-1:0] cfg_data = '0;

  page_fault_replacement_engine_unit dut (.*);

  always #6 clk = ~clk;

  // One fault report as the block returns it.
  typedef struct packed {
    logic bad;
    logic [pfre_pkg::PG_W-1:0] vpage;
    logic [2:0] why;
    logic signed [pfre_pkg::PG_W:0] victim;
    logic wb;
    logic [pfre_pkg::PA_W-1:0] paddr;
  } fault_report_t;

  fault_report_t pending_reports[$];
  int mismatches = 0;
  int words_in = 0;
  int words_out = 0;
  int evictions = 0;
  longint cycle_count = 0;

  // Shadow of the engine's configuration and per-page marks.
  logic pol;
  int nframes, pshift, npages;
  int order_q[$];
  bit listed[pfre_pkg::VPAGES];
  bit resident[pfre_pkg::VPAGES];
  int frame_of[pfre_pkg::VPAGES];
  bit ro[pfre_pkg::VPAGES];
  bit refd[pfre_pkg::VPAGES];
  logic [1:0] dirty[pfre_pkg::VPAGES];
  int frames_used;
  int hand;

  function automatic void shadow_reset();
    pol = pfre_pkg::POLICY_FIFO;
    nframes = 16;
    pshift = 12;
    npages = 64;
    order_q.delete();
    for (int p = 0; p < pfre_pkg::VPAGES; p++) begin
      listed[p] = 0; resident[p] = 0; frame_of[p] = 0;
      ro[p] = 0; refd[p] = 0; dirty[p] = 2'b00;
    end
    frames_used = 0;
    hand = 0;
  endfunction

  function automatic void drop_from_order(int pg);
    for (int k = 0; k < order_q.size(); k++) begin
      if (order_q[k] == pg) begin
        order_q.delete(k);
        return;
      end
    end
  endfunction

  // Computes the report for one fault word and updates the shadow marks.
  function automatic fault_report_t resolve_fault(logic [pfre_pkg::OFF_W-1:0] off,
                                                  logic wr);
    fault_report_t r;
    int sh, np, nf, pg, frame, poff;
    bit is_new, found, any;
    int start, i, q;
    r = '0;
    sh = (pshift > pfre_pkg::MAX_SHIFT) ? pfre_pkg::MAX_SHIFT : pshift;
    np = (npages > pfre_pkg::VPAGES) ? pfre_pkg::VPAGES : npages;
    nf = (nframes < 1) ? 1 : ((nframes > pfre_pkg::FRAMES) ? pfre_pkg::FRAMES : nframes);
    frame = 0;
    r.victim = '1;
    if ((int'(off) >> sh) >= np) begin
      r = '0;
      r.bad = 1'b1;
      return r;
    end
    pg = int'(off) >> sh;
    poff = int'(off) & ((1 << sh) - 1);
    if (!listed[pg] || !resident[pg]) begin
      is_new = !listed[pg];
      if (wr) begin
        r.why = pfre_pkg::CAUSE_WRITE_NEW; refd[pg] = 1; dirty[pg] = pfre_pkg::DIRTY_ALL;
      end else begin
        r.why = pfre_pkg::CAUSE_READ_NEW; ro[pg] = 1; refd[pg] = 1;
      end
      if (frames_used < nf) begin
        frame = frames_used;
        frames_used++;
        if (is_new) begin
          order_q.push_back(pg);
          listed[pg] = 1;
        end
      end else if (pol == pfre_pkg::POLICY_FIFO) begin
        for (int k = 0; k < order_q.size(); k++) begin
          q = order_q[k];
          if (resident[q]) begin
            order_q.delete(k);
            frame = frame_of[q];
            r.victim = {1'b0, q[pfre_pkg::PG_W-1:0]};
            r.wb = (dirty[q] != 2'b00);
            resident[q] = 0; frame_of[q] = 0; ro[q] = 0; refd[q] = 0; dirty[q] = '0;
            order_q.push_back(q);
            break;
          end
        end
        if (!is_new) drop_from_order(pg);
        order_q.push_back(pg);
        listed[pg] = 1;
      end else begin
        found = 0;
        forever begin
          start = hand;
          any = 0;
          i = hand;
          while (i < order_q.size()) begin
            q = order_q[i];
            hand++;
            if (resident[q]) begin
              any = 1;
              if (refd[q]) refd[q] = 0;
              else if (dirty[q][1]) dirty[q] = pfre_pkg::DIRTY_OLD;
              else begin
                found = 1;
                r.victim = {1'b0, q[pfre_pkg::PG_W-1:0]};
                frame = frame_of[q];
                resident[q] = 0; frame_of[q] = 0;
                if (dirty[q][0]) begin
                  dirty[q] = '0; r.wb = 1;
                end
                break;
              end
            end
            i++;
          end
          if (!found || i + 1 >= order_q.size()) hand = 0;
          if (found) break;
          if (!any && start == 0) break;
        end
        if (is_new) begin
          order_q.push_back(pg);
          listed[pg] = 1;
        end
      end
      frame_of[pg] = frame;
      resident[pg] = 1;
    end else begin
      frame = frame_of[pg];
      refd[pg] = 1;
      if (wr) begin
        r.why = ro[pg] ? pfre_pkg::CAUSE_WRITE_RO : pfre_pkg::CAUSE_WRITE_WRITABLE;
        ro[pg] = 0;
        dirty[pg] = pfre_pkg::DIRTY_ALL;
      end else begin
        r.why = pfre_pkg::CAUSE_READ_RESIDENT;
      end
    end
    r.vpage = pg[pfre_pkg::PG_W-1:0];
    r.paddr = pfre_pkg::PA_W'((frame << sh) + poff);
    return r;
  endfunction

  // Writes one register at an idle moment and mirrors it in the shadow.
  task automatic write_reg(logic [1:0] idx, int val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= pfre_pkg::CFG_W'(val);
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      pfre_pkg::CFG_POLICY: pol = val[0];
      pfre_pkg::CFG_NUM_FRAMES: nframes = val & 5'h1f;
      pfre_pkg::CFG_PAGE_SHIFT: pshift = val & 4'hf;
      pfre_pkg::CFG_NUM_PAGES: npages = val & 7'h7f;
      default: ;
    endcase
  endtask

  // Sends one word; the expected report is predicted when the word is taken.
  // With chk set, the predicted report is also compared with a hand-written one.
  // Valid stays up after the accepting edge until the next word or a drain.
  task automatic send_fault(logic [pfre_pkg::OFF_W-1:0] off, logic wr, bit chk = 0,
                            fault_report_t hand_r = '0);
    int gap;
    fault_report_t r;
    gap = $urandom_range(0, 10);
    if ($urandom_range(0, 3) == 0) gap = 0;
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    fault_offset <= off;
    is_write <= wr;
    do @(posedge clk); while (in_stall);
    r = resolve_fault(off, wr);
    if (chk && r !== hand_r) begin
      $display("%0t: directed row predictor disagrees: expected %h, got %h",
               $time, hand_r, r);
      mismatches++;
    end
    pending_reports.push_back(r);
    words_in++;
  endtask

  // Drops valid, waits until every report has come back, then lets the
  // engine settle.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  // Output side: a random wait per word, then each report is checked field
  // by field.
  initial begin
    fault_report_t e, a;
    int wait_left;
    wait_left = $urandom_range(0, 10);
    forever begin
      @(negedge clk);
      out_stall <= (wait_left != 0);
      @(posedge clk);
      if (!rst && out_valid) begin
        if (out_stall) begin
          wait_left--;
        end else begin
          wait_left = $urandom_range(0, 10);
          a = {bad_address, virtual_page, cause, evicted_page, write_back,
               physical_address};
          words_out++;
          if (pending_reports.size() == 0) begin
            $display("%0t: unexpected word %h", $time, a);
            mismatches++;
          end else begin
            e = pending_reports.pop_front();
            if (a.victim != -1) evictions++;
            if (a.bad !== e.bad) begin
              $display("%0t: bad_address expected %0d got %0d", $time, e.bad, a.bad);
              mismatches++;
            end
            if (a.vpage !== e.vpage) begin
              $display("%0t: virtual_page expected %0d got %0d", $time, e.vpage, a.vpage);
              mismatches++;
            end
            if (a.why !== e.why) begin
              $display("%0t: cause expected %0d got %0d", $time, e.why, a.why);
              mismatches++;
            end
            if (a.victim !== e.victim) begin
              $display("%0t: evicted_page expected %0d got %0d", $time, e.victim,
                       a.victim);
              mismatches++;
            end
            if (a.wb !== e.wb) begin
              $display("%0t: write_back expected %0d got %0d", $time, e.wb, a.wb);
              mismatches++;
            end
            if (a.paddr !== e.paddr) begin
              $display("%0t: physical_address expected %h got %h", $time, e.paddr,
                       a.paddr);
              mismatches++;
            end
          end
        end
      end
    end
  end

  // Generous cycle limit for about 950 words, the engine's replacement walks
  // and both sides' gaps included.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 3000000) begin
      $display("page_fault_replacement_engine_unit test failed");
      $finish;
    end
  end

  typedef struct {
    logic [pfre_pkg::OFF_W-1:0] off;
    logic wr;
    bit chk;
    fault_report_t exp_r;
  } fault_row_t;

  fault_row_t directed[$];

  // A random offset mostly inside the region, with a few past its end.
  function automatic logic [pfre_pkg::OFF_W-1:0] pick_offset(int hot_pages);
    int sh, np, pg;
    sh = (pshift > pfre_pkg::MAX_SHIFT) ? pfre_pkg::MAX_SHIFT : pshift;
    np = (npages > pfre_pkg::VPAGES) ? pfre_pkg::VPAGES : npages;
    if (np == 0 || $urandom_range(0, 19) == 0) return pfre_pkg::OFF_W'($urandom);
    pg = $urandom_range(0, ((hot_pages < np) ? hot_pages : np) - 1);
    return pfre_pkg::OFF_W'((pg << sh) | ($urandom & ((1 << sh) - 1)));
  endfunction

  initial begin
    fault_report_t x;
    int hot;
    shadow_reset();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table: reset settings (4 KiB pages, 16 frames, 64 pages).
    // The first rows can be read off at a glance: a fresh read, the write
    // that upgrades it, a resident write, a write to the last byte of the
    // region, and a fresh page with a read that follows it.
    x = '0; x.why = pfre_pkg::CAUSE_READ_NEW; x.victim = '1; x.paddr = 16'h0123;
    directed.push_back('{18'h00123, 1'b0, 1, x});
    x.why = pfre_pkg::CAUSE_WRITE_RO; x.paddr = 16'h0456;
    directed.push_back('{18'h00456, 1'b1, 1, x});
    x.why = pfre_pkg::CAUSE_WRITE_WRITABLE; x.paddr = 16'h0fff;
    directed.push_back('{18'h00fff, 1'b1, 1, x});
    x = '0; x.vpage = 63; x.why = pfre_pkg::CAUSE_WRITE_NEW; x.victim = '1;
    x.paddr = 16'h1fff;
    directed.push_back('{18'h3ffff, 1'b1, 1, x});
    directed.push_back('{18'h3f000, 1'b0, 0, x});
    x = '0; x.vpage = 1; x.why = pfre_pkg::CAUSE_WRITE_NEW; x.victim = '1;
    x.paddr = 16'h2000;
    directed.push_back('{18'h01000, 1'b1, 1, x});
    x.why = pfre_pkg::CAUSE_READ_RESIDENT; x.paddr = 16'h2abc;
    directed.push_back('{18'h01abc, 1'b0, 1, x});
    foreach (directed[i])
      send_fault(directed[i].off, directed[i].wr, directed[i].chk, directed[i].exp_r);
    drain();

    // Tight FIFO: one frame, tiny pages, so every new page evicts.
    write_reg(pfre_pkg::CFG_NUM_FRAMES, 1);
    write_reg(pfre_pkg::CFG_PAGE_SHIFT, 0);
    write_reg(pfre_pkg::CFG_NUM_PAGES, 1);
    send_fault(18'd0, 1'b0);
    send_fault(18'd1, 1'b1);
    drain();
    write_reg(pfre_pkg::CFG_NUM_PAGES, 0);
    send_fault(18'd0, 1'b0);
    drain();
    write_reg(pfre_pkg::CFG_NUM_PAGES, 8);
    for (int k = 0; k < 10; k++) send_fault(pfre_pkg::OFF_W'(k % 8), k[0]);
    drain();

    // Clock policy and register values beyond their ranges.
    write_reg(pfre_pkg::CFG_POLICY, 1);
    write_reg(pfre_pkg::CFG_NUM_FRAMES, 0);
    write_reg(pfre_pkg::CFG_PAGE_SHIFT, 15);
    write_reg(pfre_pkg::CFG_NUM_PAGES, 127);
    for (int k = 0; k < 6; k++) send_fault(pfre_pkg::OFF_W'((k * 37) << 12), k[1]);
    drain();

    // Random phases over varied settings: small working sets beyond the
    // frame count make replacements frequent.
    for (int ph = 0; ph < 19; ph++) begin
      write_reg(pfre_pkg::CFG_POLICY, $urandom_range(0, 1));
      write_reg(pfre_pkg::CFG_NUM_FRAMES, (ph % 4 == 0) ? 16 : $urandom_range(0, 31));
      write_reg(pfre_pkg::CFG_PAGE_SHIFT, (ph % 5 == 0) ? $urandom_range(0, 15)
                                                        : $urandom_range(0, 12));
      write_reg(pfre_pkg::CFG_NUM_PAGES, (ph % 3 == 0) ? 64 : $urandom_range(0, 127));
      hot = $urandom_range(2, 64);
      for (int k = 0; k < 48; k++) send_fault(pick_offset(hot), $urandom_range(0, 1));
      drain();
    end

    $display("Covered %0d words in, %0d reports out, %0d evictions,", words_in,
             words_out, evictions);
    $display("over FIFO and clock policies with frame, page and size extremes.");
    if (mismatches == 0 && pending_reports.size() == 0) begin
      $display("page_fault_replacement_engine_unit test passed");
    end else begin
      $display("page_fault_replacement_engine_unit test failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/pfre_pkg.sv
hdl/pfre_attr_ram.sv
hdl/pfre_order_ram.sv
hdl/page_fault_replacement_engine_unit.sv
hdl/pfre_checker.sv
sim/page_fault_replacement_engine_unit_tb.sv
